// File: rtl/pnf_pkg.sv
// Shared constants and types for the pink noise filter with sample and hold.
package pnf_pkg;

   // Default number of voices and the fixed field widths.
   localparam int VOICES_DEFAULT = 8;
   localparam int VOICE_W        = 3;
   localparam int SAMPLE_W       = 16;
   localparam int PINK_W         = 23;
   localparam int POLE_W         = 32;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_INDEX_W    = 1;

   // Filter constants are in Q.24 and held in a signed container.
   localparam int COEF_W      = 26;
   localparam int FRAC_SHIFT  = 24;
   localparam int DRIVE_SHIFT = 9;
   localparam int PINK_SHIFT  = 15;
   localparam int HOLD_SHIFT  = 15;
   localparam int WG_W        = SAMPLE_W + COEF_W;
   localparam int HOLD_PROD_W = SAMPLE_W + SAMPLE_W + 1;

   localparam logic signed [COEF_W-1:0] A_SLOW   = 26'sd16737790;
   localparam logic signed [COEF_W-1:0] A_MID    = 26'sd16156459;
   localparam logic signed [COEF_W-1:0] A_FAST   = 26'sd9563013;
   localparam logic signed [COEF_W-1:0] G_SLOW   = 26'sd1661716;
   localparam logic signed [COEF_W-1:0] G_MID    = 26'sd4974720;
   localparam logic signed [COEF_W-1:0] G_FAST   = 26'sd17661229;
   localparam logic signed [COEF_W-1:0] G_DIRECT = 26'sd3100430;

   localparam logic [CSR_DATA_W-1:0] HOLD_PERIOD_RESET = 16'd25100;
   localparam logic [CSR_DATA_W-1:0] HOLD_LEVEL_RESET  = 16'd16384;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOLD_PERIOD = 1'b0,
      CSR_HOLD_LEVEL  = 1'b1
   } csr_index_type;

   // One word of the per-voice state memory.
   typedef struct packed {
      logic signed [POLE_W-1:0]   slow;
      logic signed [POLE_W-1:0]   middle;
      logic signed [POLE_W-1:0]   fast;
      logic signed [SAMPLE_W-1:0] held;
   } voice_state_type;

endpackage

// File: rtl/pnf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module pnf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read and a write to the same entry in one cycle return the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/pnf_pole.sv
// One-pole section update: multiply, add the input drive, round and saturate.
module pnf_pole (
   input  logic signed [pnf_pkg::POLE_W-1:0] pole,
   input  logic signed [pnf_pkg::COEF_W-1:0] coef,
   input  logic signed [pnf_pkg::WG_W-1:0]   drive,
   output logic signed [pnf_pkg::POLE_W-1:0] pole_next
);

   localparam int PROD_W = pnf_pkg::POLE_W + pnf_pkg::COEF_W;
   localparam int ACC_W  = PROD_W + 1;
   localparam int SH_W   = ACC_W - pnf_pkg::FRAC_SHIFT;
   localparam logic signed [ACC_W-1:0] HALF =
      {{(ACC_W - pnf_pkg::FRAC_SHIFT){1'b0}}, 1'b1, {(pnf_pkg::FRAC_SHIFT - 1){1'b0}}};

   logic signed [PROD_W-1:0] feedback;
   logic signed [ACC_W-1:0]  acc;
   logic signed [SH_W-1:0]   shifted;
   logic [SH_W-pnf_pkg::POLE_W:0] top_bits;

   assign feedback = pole * coef;
   assign acc      = ACC_W'(feedback) + (ACC_W'(drive) <<< pnf_pkg::DRIVE_SHIFT) + HALF;
   assign shifted  = acc[ACC_W-1:pnf_pkg::FRAC_SHIFT];
   assign top_bits = shifted[SH_W-1:pnf_pkg::POLE_W-1];

   // The bits above the result's sign must all agree, else clamp.
   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         pole_next = shifted[pnf_pkg::POLE_W-1:0];
      end else if (shifted[SH_W-1]) begin
         pole_next = {1'b1, {(pnf_pkg::POLE_W - 1){1'b0}}};
      end else begin
         pole_next = {1'b0, {(pnf_pkg::POLE_W - 1){1'b1}}};
      end
   end

endmodule

// File: rtl/pink_noise_filter_with_hold.sv
// Top level of the per-voice pink noise filter with a shared sample-and-hold refresh.
//
//   Channel   Direction   Handshake           Carries
//   req_*     in          req_valid/ready     voice, frame start, white and hold samples
//   rsp_*     out         rsp_valid/ready     voice, white, pink (Q8.15) and held values
//   csr_*     in          csr_wr_en only      hold period and hold level registers
//
// The block accepts one request every cycle while no response is held up, and passes
// it through stage 1, stage 2 and the output register; the rate is set by the voice state
// memory, read at acceptance and written back from stage 1; forwarding covers the gap.
// Reset is synchronous and clears the control state and the per-voice valid bits;
// a voice whose valid bit is clear reads as all zero state, so there is no clearing pass.
// When the response is not taken, the whole pipeline holds and req_ready drops.
module pink_noise_filter_with_hold #(
   parameter int VOICES = pnf_pkg::VOICES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [pnf_pkg::VOICE_W-1:0]            req_voice,
   input  logic                                   req_frame_start,
   input  logic signed [pnf_pkg::SAMPLE_W-1:0]    req_white_sample,
   input  logic signed [pnf_pkg::SAMPLE_W-1:0]    req_hold_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [pnf_pkg::VOICE_W-1:0]            rsp_voice_out,
   output logic signed [pnf_pkg::SAMPLE_W-1:0]    rsp_white_out,
   output logic signed [pnf_pkg::PINK_W-1:0]      rsp_pink_out,
   output logic signed [pnf_pkg::SAMPLE_W-1:0]    rsp_held_out,
   input  logic                                   csr_wr_en,
   input  logic [pnf_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [pnf_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int ADDR_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int STATE_W  = $bits(pnf_pkg::voice_state_type);
   localparam int SUM_W    = pnf_pkg::POLE_W + 2;
   localparam int PACC_W   = SUM_W + pnf_pkg::PINK_SHIFT + 1;
   localparam int PSH_W    = PACC_W - pnf_pkg::FRAC_SHIFT;
   localparam int HACC_W   = pnf_pkg::HOLD_PROD_W + 1;
   localparam int HSH_W    = HACC_W - pnf_pkg::HOLD_SHIFT;
   localparam int CNT_W    = pnf_pkg::CSR_DATA_W;
   localparam logic signed [PACC_W-1:0] PINK_HALF =
      {{(PACC_W - pnf_pkg::FRAC_SHIFT){1'b0}}, 1'b1, {(pnf_pkg::FRAC_SHIFT - 1){1'b0}}};
   localparam logic signed [HACC_W-1:0] HOLD_HALF =
      {{(HACC_W - pnf_pkg::HOLD_SHIFT){1'b0}}, 1'b1, {(pnf_pkg::HOLD_SHIFT - 1){1'b0}}};

   // Pipeline advance: everything moves together whenever the output slot frees up.
   logic pipe_en;
   logic req_accept;

   // Configuration registers.
   logic [pnf_pkg::CSR_DATA_W-1:0] hold_period_ff;
   logic [pnf_pkg::CSR_DATA_W-1:0] hold_level_ff;

   // Shared frame counter and the refresh flag of the current frame.
   logic [CNT_W-1:0] frame_counter_ff;
   logic [CNT_W-1:0] frame_counter_in;
   logic             refresh_ff;
   logic             refresh_in;
   logic [CNT_W:0]   frame_next;
   logic             frame_wrap;
   logic             item_refresh;

   logic              req_ok;
   logic [ADDR_W-1:0] req_addr;

   // Per-voice valid bits stand in for clearing the state memory.
   logic [VOICES-1:0] entry_valid_ff;

   // Stage 1: products registered, state word arriving from the memory.
   logic                                s1_valid_ff;
   logic                                s1_ok_ff;
   logic                                s1_refresh_ff;
   logic                                s1_entry_valid_ff;
   logic [pnf_pkg::VOICE_W-1:0]         s1_voice_ff;
   logic signed [pnf_pkg::SAMPLE_W-1:0] s1_white_ff;
   logic signed [pnf_pkg::WG_W-1:0]     s1_wg_slow_ff;
   logic signed [pnf_pkg::WG_W-1:0]     s1_wg_mid_ff;
   logic signed [pnf_pkg::WG_W-1:0]     s1_wg_fast_ff;
   logic signed [pnf_pkg::WG_W-1:0]     s1_wd_ff;
   logic signed [pnf_pkg::HOLD_PROD_W-1:0] s1_hold_prod_ff;
   logic [ADDR_W-1:0]                   s1_addr;
   logic                                s1_forward;
   pnf_pkg::voice_state_type            ram_rd_data;
   logic [STATE_W-1:0]                  ram_rd_bits;
   pnf_pkg::voice_state_type            s1_state;
   pnf_pkg::voice_state_type            s2_state_in;
   logic                                ram_wr_en;

   logic signed [HACC_W-1:0]             hold_acc;
   logic signed [HSH_W-1:0]              hold_shifted;
   logic [HSH_W-pnf_pkg::SAMPLE_W:0]     hold_top;
   logic signed [pnf_pkg::SAMPLE_W-1:0]  hold_new;

   // Stage 2: updated state, pink sum being formed.
   logic                                s2_valid_ff;
   logic                                s2_ok_ff;
   logic [pnf_pkg::VOICE_W-1:0]         s2_voice_ff;
   logic signed [pnf_pkg::SAMPLE_W-1:0] s2_white_ff;
   logic signed [pnf_pkg::WG_W-1:0]     s2_wd_ff;
   pnf_pkg::voice_state_type            s2_state_ff;

   logic signed [SUM_W-1:0]              pole_sum;
   logic signed [PACC_W-1:0]             pink_acc;
   logic signed [PSH_W-1:0]              pink_shifted;
   logic [PSH_W-pnf_pkg::PINK_W:0]       pink_top;
   logic signed [pnf_pkg::PINK_W-1:0]    pink_in;

   // Output register.
   logic                                rsp_valid_ff;
   logic [pnf_pkg::VOICE_W-1:0]         rsp_voice_ff;
   logic signed [pnf_pkg::SAMPLE_W-1:0] rsp_white_ff;
   logic signed [pnf_pkg::PINK_W-1:0]   rsp_pink_ff;
   logic signed [pnf_pkg::SAMPLE_W-1:0] rsp_held_ff;

   assign pipe_en    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = pipe_en;
   assign req_accept = req_valid && req_ready;

   // Configuration writes must arrive only while the block is idle; the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_period_ff <= pnf_pkg::HOLD_PERIOD_RESET;
         hold_level_ff  <= pnf_pkg::HOLD_LEVEL_RESET;
      end else if (csr_wr_en) begin
         unique case (pnf_pkg::csr_index_type'(csr_index))
            pnf_pkg::CSR_HOLD_PERIOD: hold_period_ff <= csr_wdata;
            pnf_pkg::CSR_HOLD_LEVEL:  hold_level_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A frame start advances the counter; passing the hold period clears it and
   // marks the frame for a refresh. The compare is done one bit wider than the
   // counter so that a period of all ones still wraps.
   assign frame_next   = {1'b0, frame_counter_ff} + (CNT_W + 1)'(1);
   assign frame_wrap   = frame_next > {1'b0, hold_period_ff};
   assign item_refresh = req_frame_start ? frame_wrap : refresh_ff;

   always_comb begin
      frame_counter_in = frame_counter_ff;
      refresh_in       = refresh_ff;
      if (req_accept && req_frame_start) begin
         frame_counter_in = frame_wrap ? '0 : frame_next[CNT_W-1:0];
         refresh_in       = frame_wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_counter_ff <= '0;
         refresh_ff       <= 1'b0;
      end else begin
         frame_counter_ff <= frame_counter_in;
         refresh_ff       <= refresh_in;
      end
   end

   // Voices at or above VOICES run from zero state and leave nothing behind.
   assign req_ok   = 32'(req_voice) < VOICES;
   assign req_addr = ADDR_W'(req_voice);
   assign s1_addr  = ADDR_W'(s1_voice_ff);

   // Stage 1 capture: all multiplications by the request's samples happen here,
   // in parallel with the state memory read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_ok_ff          <= req_ok;
         s1_refresh_ff     <= item_refresh;
         s1_entry_valid_ff <= req_ok && entry_valid_ff[req_addr];
         s1_voice_ff       <= req_voice;
         s1_white_ff       <= req_white_sample;
         s1_wg_slow_ff     <= req_white_sample * pnf_pkg::G_SLOW;
         s1_wg_mid_ff      <= req_white_sample * pnf_pkg::G_MID;
         s1_wg_fast_ff     <= req_white_sample * pnf_pkg::G_FAST;
         s1_wd_ff          <= req_white_sample * pnf_pkg::G_DIRECT;
         s1_hold_prod_ff   <= $signed({1'b0, hold_level_ff}) * req_hold_sample;
      end
   end

   pnf_ram #(
      .WIDTH(STATE_W),
      .DEPTH(VOICES)
   ) u_state_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(s1_addr),
      .wr_data(s2_state_in),
      .rd_en  (pipe_en),
      .rd_addr(req_addr),
      .rd_data(ram_rd_bits)
   );

   assign ram_rd_data = pnf_pkg::voice_state_type'(ram_rd_bits);

   // The request one ahead wrote its voice at the same edge this one was read,
   // so the memory returned the old word; take the newer one from stage 2.
   assign s1_forward = s2_valid_ff && s2_ok_ff && (s2_voice_ff == s1_voice_ff);

   always_comb begin
      if (!s1_ok_ff) begin
         s1_state = '0;
      end else if (s1_forward) begin
         s1_state = s2_state_ff;
      end else if (s1_entry_valid_ff) begin
         s1_state = ram_rd_data;
      end else begin
         s1_state = '0;
      end
   end

   pnf_pole u_pole_slow (
      .pole     (s1_state.slow),
      .coef     (pnf_pkg::A_SLOW),
      .drive    (s1_wg_slow_ff),
      .pole_next(s2_state_in.slow)
   );

   pnf_pole u_pole_mid (
      .pole     (s1_state.middle),
      .coef     (pnf_pkg::A_MID),
      .drive    (s1_wg_mid_ff),
      .pole_next(s2_state_in.middle)
   );

   pnf_pole u_pole_fast (
      .pole     (s1_state.fast),
      .coef     (pnf_pkg::A_FAST),
      .drive    (s1_wg_fast_ff),
      .pole_next(s2_state_in.fast)
   );

   // Held value reload: round the level times hold sample back to Q1.15 and clamp.
   assign hold_acc     = HACC_W'(s1_hold_prod_ff) + HOLD_HALF;
   assign hold_shifted = hold_acc[HACC_W-1:pnf_pkg::HOLD_SHIFT];
   assign hold_top     = hold_shifted[HSH_W-1:pnf_pkg::SAMPLE_W-1];

   always_comb begin
      if ((&hold_top) || !(|hold_top)) begin
         hold_new = hold_shifted[pnf_pkg::SAMPLE_W-1:0];
      end else if (hold_shifted[HSH_W-1]) begin
         hold_new = {1'b1, {(pnf_pkg::SAMPLE_W - 1){1'b0}}};
      end else begin
         hold_new = {1'b0, {(pnf_pkg::SAMPLE_W - 1){1'b1}}};
      end
   end

   // In a refresh frame every request reloads its own voice, even a repeated one.
   assign s2_state_in.held = (s1_ok_ff && s1_refresh_ff) ? hold_new : s1_state.held;

   assign ram_wr_en = pipe_en && s1_valid_ff && s1_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (ram_wr_en) begin
         entry_valid_ff[s1_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_ok_ff    <= s1_ok_ff;
         s2_voice_ff <= s1_voice_ff;
         s2_white_ff <= s1_white_ff;
         s2_wd_ff    <= s1_wd_ff;
         s2_state_ff <= s2_state_in;
      end
   end

   // Pink output: the three poles shifted up by PINK_SHIFT to line up with the direct term,
   // rounded to Q8.15 and clamped to the output range.
   assign pole_sum     = SUM_W'(s2_state_ff.slow) + SUM_W'(s2_state_ff.middle)
                       + SUM_W'(s2_state_ff.fast);
   assign pink_acc     = (PACC_W'(pole_sum) <<< pnf_pkg::PINK_SHIFT) + PACC_W'(s2_wd_ff)
                       + PINK_HALF;
   assign pink_shifted = pink_acc[PACC_W-1:pnf_pkg::FRAC_SHIFT];
   assign pink_top     = pink_shifted[PSH_W-1:pnf_pkg::PINK_W-1];

   always_comb begin
      if ((&pink_top) || !(|pink_top)) begin
         pink_in = pink_shifted[pnf_pkg::PINK_W-1:0];
      end else if (pink_shifted[PSH_W-1]) begin
         pink_in = {1'b1, {(pnf_pkg::PINK_W - 1){1'b0}}};
      end else begin
         pink_in = {1'b0, {(pnf_pkg::PINK_W - 1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_voice_ff <= s2_voice_ff;
         rsp_white_ff <= s2_white_ff;
         rsp_pink_ff  <= pink_in;
         rsp_held_ff  <= s2_state_ff.held;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_voice_out = rsp_voice_ff;
   assign rsp_white_out = rsp_white_ff;
   assign rsp_pink_out  = rsp_pink_ff;
   assign rsp_held_out  = rsp_held_ff;

   // No response is pending in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A frame start at or past the hold period wraps the counter and flags a refresh.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_frame_start && (frame_counter_ff >= hold_period_ff))
      |=> (frame_counter_ff == '0) && refresh_ff)
      else $error("frame counter did not wrap into a refresh frame");

   // The state memory is never written while the pipeline is held.
   assert property (@(posedge clock) disable iff (reset) !pipe_en |-> !ram_wr_en)
      else $error("state write during a stall");

   // A forwarded word always belongs to a voice that has already been written.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_forward) |-> s1_ok_ff && entry_valid_ff[s1_addr])
      else $error("forwarding without a preceding state write");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the per-voice pink noise filter with sample-and-hold refresh.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Filter constants in Q.24, the value times 2^24 rounded to nearest.
   localparam longint K_SLOW_POLE = 64'sd16737790;   // 0.99765
   localparam longint K_MID_POLE  = 64'sd16156459;   // 0.963
   localparam longint K_FAST_POLE = 64'sd9563013;    // 0.57
   localparam longint K_SLOW_GAIN = 64'sd1661716;    // 0.099046
   localparam longint K_MID_GAIN  = 64'sd4974720;    // 0.2965164
   localparam longint K_FAST_GAIN = 64'sd17661229;   // 1.0526913
   localparam longint K_DIRECT    = 64'sd3100430;    // 0.1848
   localparam longint ROUND_HALF  = 64'sd8388608;    // half of one step after a 24-bit shift
   localparam longint POLE_MAX    = 64'sd2147483647;
   localparam longint POLE_MIN    = -64'sd2147483648;
   localparam longint PINK_MAX    = 64'sd4194303;
   localparam longint PINK_MIN    = -64'sd4194304;
   localparam longint HELD_MAX    = 64'sd32767;
   localparam longint HELD_MIN    = -64'sd32768;

   // A short stretch at the largest period, every request starting a frame.
   localparam int WIDE_ITEMS     = 24;
   localparam int LONG_HOLD_OFF  = 80;
   localparam int MAX_PRINTED    = 40;

   typedef struct packed {
      logic [pnf_pkg::VOICE_W-1:0]         voice;
      logic                                frame_start;
      logic signed [pnf_pkg::SAMPLE_W-1:0] white;
      logic signed [pnf_pkg::SAMPLE_W-1:0] hold;
   } pink_request_type;

   typedef struct packed {
      logic [pnf_pkg::VOICE_W-1:0]         voice;
      logic signed [pnf_pkg::SAMPLE_W-1:0] white;
      logic signed [pnf_pkg::PINK_W-1:0]   pink;
      logic signed [pnf_pkg::SAMPLE_W-1:0] held;
   } pink_result_type;

   // A directed row is a request checked by the predictor, a request whose
   // response is typed in by hand, or a register write.
   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_TYPED,
      ROW_WRITE
   } row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      pink_request_type                rq;
      pink_result_type                 want;
      pnf_pkg::csr_index_type          reg_index;
      logic [pnf_pkg::CSR_DATA_W-1:0]  reg_value;
   } script_row_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic [pnf_pkg::VOICE_W-1:0]          req_voice;
   logic                                 req_frame_start;
   logic signed [pnf_pkg::SAMPLE_W-1:0]  req_white_sample;
   logic signed [pnf_pkg::SAMPLE_W-1:0]  req_hold_sample;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [pnf_pkg::VOICE_W-1:0]          rsp_voice_out;
   logic signed [pnf_pkg::SAMPLE_W-1:0]  rsp_white_out;
   logic signed [pnf_pkg::PINK_W-1:0]    rsp_pink_out;
   logic signed [pnf_pkg::SAMPLE_W-1:0]  rsp_held_out;
   logic                                 csr_wr_en;
   logic [pnf_pkg::CSR_INDEX_W-1:0]      csr_index;
   logic [pnf_pkg::CSR_DATA_W-1:0]       csr_wdata;

   // Predictor state: the three pole accumulators (Q8.24) and the held value
   // (Q1.15) of every voice, the shared frame counter and the refresh flag.
   logic signed [pnf_pkg::POLE_W-1:0]    slow_acc [8];
   logic signed [pnf_pkg::POLE_W-1:0]    mid_acc [8];
   logic signed [pnf_pkg::POLE_W-1:0]    fast_acc [8];
   logic signed [pnf_pkg::SAMPLE_W-1:0]  held_store [8];
   logic [15:0]                          frame_count;
   logic                                 in_refresh;

   // Our copy of the two registers, updated when a write goes out.
   logic [pnf_pkg::CSR_DATA_W-1:0]       hold_period_q;
   logic [pnf_pkg::CSR_DATA_W-1:0]       hold_level_q;

   // Responses that are owed, oldest first.
   pink_result_type             pending_results[$];

   int mismatch_count  = 0;
   int results_checked = 0;
   int requests_sent   = 0;
   int refresh_frames  = 0;
   int rsp_stall_pct   = 0;
   int hold_off_asks   = 0;

   pink_noise_filter_with_hold uut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // One-pole section: p' = round((p*a + w*g*2^9) / 2^24), saturated to 32 bits.
   function automatic logic signed [pnf_pkg::POLE_W-1:0] pole_next(
         input logic signed [pnf_pkg::POLE_W-1:0] p,
         input longint a,
         input longint w,
         input longint g);
      return 32'(clamp((longint'(p) * a + w * g * 512 + ROUND_HALF) >>> 24,
                       POLE_MIN, POLE_MAX));
   endfunction

   // Works out the response to one accepted request and advances the state.
   function automatic pink_result_type shape_noise(input pink_request_type rq);
      longint w;
      longint mix;
      longint loaded;
      int nxt;
      logic signed [pnf_pkg::POLE_W-1:0] s;
      logic signed [pnf_pkg::POLE_W-1:0] m;
      logic signed [pnf_pkg::POLE_W-1:0] f;
      pink_result_type r;
      w = longint'(rq.white);
      // The counter is compared one bit wider than it is stored, so a period
      // of 65535 still lets the count wrap into a refresh.
      if (rq.frame_start) begin
         nxt = int'(frame_count) + 1;
         if (nxt > int'(hold_period_q)) begin
            frame_count = '0;
            in_refresh = 1'b1;
            refresh_frames++;
         end else begin
            frame_count = 16'(nxt);
            in_refresh = 1'b0;
         end
      end
      s = pole_next(slow_acc[rq.voice], K_SLOW_POLE, w, K_SLOW_GAIN);
      m = pole_next(mid_acc[rq.voice], K_MID_POLE, w, K_MID_GAIN);
      f = pole_next(fast_acc[rq.voice], K_FAST_POLE, w, K_FAST_GAIN);
      slow_acc[rq.voice] = s;
      mid_acc[rq.voice] = m;
      fast_acc[rq.voice] = f;
      mix = ((longint'(s) + longint'(m) + longint'(f)) * 32768 + w * K_DIRECT + ROUND_HALF)
            >>> 24;
      // Every request of a refresh frame reloads its voice, repeats included.
      if (in_refresh) begin
         loaded = (longint'(hold_level_q) * longint'(rq.hold) + 64'sd16384) >>> 15;
         held_store[rq.voice] = 16'(clamp(loaded, HELD_MIN, HELD_MAX));
      end
      r.voice = rq.voice;
      r.white = rq.white;
      r.pink  = 23'(clamp(mix, PINK_MIN, PINK_MAX));
      r.held  = held_store[rq.voice];
      return r;
   endfunction

   // Full-scale values come up one time in four, anything else uniformly.
   function automatic logic signed [pnf_pkg::SAMPLE_W-1:0] noise_word();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Number of idle cycles before the next request, geometric in pct.
   function automatic int idle_gap(input int pct);
      int g;
      g = 0;
      while (int'($urandom_range(99)) < pct) g++;
      return g;
   endfunction

   function automatic script_row_type req_row(input row_kind_type kind, input int v,
                                              input int fs, input int w, input int h,
                                              input int pink = 0, input int held = 0);
      script_row_type r;
      r = '0;
      r.kind = kind;
      r.rq.voice = 3'(v);
      r.rq.frame_start = 1'(fs);
      r.rq.white = 16'(w);
      r.rq.hold = 16'(h);
      r.want.voice = r.rq.voice;
      r.want.white = r.rq.white;
      r.want.pink = 23'(pink);
      r.want.held = 16'(held);
      return r;
   endfunction

   function automatic script_row_type reg_row(input pnf_pkg::csr_index_type idx,
                                              input int value);
      script_row_type r;
      r = '0;
      r.kind = ROW_WRITE;
      r.reg_index = idx;
      r.reg_value = 16'(value);
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t ns  mismatch: %s", $time, what);
   endtask

   // Offers one request after an optional idle gap and waits for it to be
   // accepted. Valid is left high so that a following request can go out in
   // the very next cycle; whoever stops sending lowers it.
   task automatic send_request(input pink_request_type rq, input int gap,
                               input bit typed = 1'b0,
                               input pink_result_type typed_want = '0);
      pink_result_type predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_voice        <= rq.voice;
      req_frame_start  <= rq.frame_start;
      req_white_sample <= rq.white;
      req_hold_sample  <= rq.hold;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // The predictor runs for typed rows as well, to keep its state in step.
      predicted = shape_noise(rq);
      pending_results.push_back(typed ? typed_want : predicted);
      requests_sent++;
   endtask

   // Stops sending and waits for every owed response. It always waits on the clock
   // first, so the caller may drive valid again right after.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_register(input pnf_pkg::csr_index_type idx,
                                 input logic [pnf_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         pnf_pkg::CSR_HOLD_PERIOD: hold_period_q = value;
         pnf_pkg::CSR_HOLD_LEVEL:  hold_level_q = value;
      endcase
   endtask

   // Registers are only touched once the pipeline is empty.
   task automatic start_phase(input int period, input int level, input int stall_pct);
      wait_drained();
      write_register(pnf_pkg::CSR_HOLD_PERIOD, 16'(period));
      write_register(pnf_pkg::CSR_HOLD_LEVEL, 16'(level));
      rsp_stall_pct = stall_pct;
   endtask

   // Random traffic, mostly in well-formed frames: a frame start on the first
   // request and then a run of voices, now and then a voice repeated. About
   // one frame in seven is a lone request with a random start flag instead,
   // and one in ten drives a full-scale constant into every voice of the frame
   // so the slow pole climbs far from zero.
   task automatic run_frames(input int n_items, input int idle_pct);
      int sent;
      int flen;
      int base;
      int k;
      bit lone;
      bit steady_frame;
      logic signed [pnf_pkg::SAMPLE_W-1:0] steady;
      pink_request_type rq;
      sent = 0;
      while (sent < n_items) begin
         lone = ($urandom_range(6) == 0);
         flen = lone ? 1 : int'($urandom_range(8, 1));
         base = int'($urandom_range(7));
         steady_frame = ($urandom_range(9) == 0);
         steady = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         for (k = 0; k < flen; k++) begin
            rq.voice = ($urandom_range(5) == 0) ? 3'($urandom_range(7)) : 3'(base + k);
            rq.frame_start = lone ? 1'($urandom_range(1)) : (k == 0);
            rq.white = steady_frame ? steady : noise_word();
            rq.hold = noise_word();
            send_request(rq, idle_gap(idle_pct));
         end
         sent += flen;
      end
   endtask

   // Response side. Ready is random at the current stall rate, except for a
   // long hold-off whenever the stimulus asks for one; this process counts
   // the cycles of that hold-off itself.
   initial begin : rsp_side
      int hold_left;
      int holds_taken;
      hold_left = 0;
      holds_taken = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_taken != hold_off_asks) begin
            holds_taken = hold_off_asks;
            hold_left = LONG_HOLD_OFF;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (int'($urandom_range(99)) >= rsp_stall_pct);
         end
      end
   end

   // Every accepted response is compared field by field with the oldest one
   // owed. A response with nothing owed is a failure of its own.
   always @(posedge clock) begin : rsp_check
      pink_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("response for voice %0d with nothing owed", rsp_voice_out));
         end else begin
            want = pending_results.pop_front();
            if (rsp_voice_out !== want.voice)
               flag_mismatch($sformatf("voice_out %0d, expected %0d",
                                       rsp_voice_out, want.voice));
            if (rsp_white_out !== want.white)
               flag_mismatch($sformatf("voice %0d white_out %0d, expected %0d",
                                       want.voice, rsp_white_out, want.white));
            if (rsp_pink_out !== want.pink)
               flag_mismatch($sformatf("voice %0d pink_out %0d, expected %0d",
                                       want.voice, rsp_pink_out, want.pink));
            if (rsp_held_out !== want.held)
               flag_mismatch($sformatf("voice %0d held_out %0d, expected %0d",
                                       want.voice, rsp_held_out, want.held));
         end
      end
   end

   initial begin : stimulus
      script_row_type script[$];
      pink_request_type rq;
      int n;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_voice        <= '0;
      req_frame_start  <= 1'b0;
      req_white_sample <= '0;
      req_hold_sample  <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= pnf_pkg::CSR_HOLD_PERIOD;
      csr_wdata        <= '0;

      // The predictor starts from the reset state of the block.
      for (n = 0; n < 8; n++) begin
         slow_acc[n] = '0;
         mid_acc[n] = '0;
         fast_acc[n] = '0;
         held_store[n] = '0;
      end
      frame_count = '0;
      in_refresh = 1'b0;
      hold_period_q = 16'd25100;
      hold_level_q = 16'd16384;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Right after reset a silent request on a fresh voice
      // gives all zeros, with the default period far away.
      script.push_back(req_row(ROW_TYPED, 0, 1, 0, 0, 0, 0));
      // Full-scale white of both signs, and minus one.
      script.push_back(req_row(ROW_ITEM, 7, 0, 32767, -32768));
      script.push_back(req_row(ROW_ITEM, 7, 0, -32768, 32767));
      script.push_back(req_row(ROW_ITEM, 3, 0, -1, 1));
      script.push_back(req_row(ROW_ITEM, 0, 1, 1, 0));
      // With a period of zero every frame start opens a refresh frame. Voice 1
      // repeats inside the frame and must reload both times; voice 2 lands on
      // the rounding midpoint of the hold product.
      script.push_back(reg_row(pnf_pkg::CSR_HOLD_PERIOD, 0));
      script.push_back(req_row(ROW_ITEM, 1, 1, 32767, 32767));
      script.push_back(req_row(ROW_ITEM, 1, 0, 32767, -32768));
      script.push_back(req_row(ROW_ITEM, 2, 0, -12345, -1));
      // A hold level above one saturates the held value at both ends. Voices 6
      // and 5 are still at rest, so with silent white their pink output is zero.
      script.push_back(reg_row(pnf_pkg::CSR_HOLD_LEVEL, 65535));
      script.push_back(req_row(ROW_TYPED, 6, 1, 0, 32767, 0, 32767));
      script.push_back(req_row(ROW_TYPED, 5, 0, 0, -32768, 0, -32768));
      // A level of exactly one, then zero.
      script.push_back(reg_row(pnf_pkg::CSR_HOLD_LEVEL, 32768));
      script.push_back(req_row(ROW_ITEM, 7, 1, 32767, -32768));
      script.push_back(req_row(ROW_ITEM, 4, 0, 21845, 32767));
      script.push_back(reg_row(pnf_pkg::CSR_HOLD_LEVEL, 0));
      script.push_back(req_row(ROW_ITEM, 3, 1, -21846, 12345));
      // A period of two: two plain frames, then a refresh frame that covers
      // every request up to the next frame start.
      script.push_back(reg_row(pnf_pkg::CSR_HOLD_PERIOD, 2));
      script.push_back(reg_row(pnf_pkg::CSR_HOLD_LEVEL, 16384));
      script.push_back(req_row(ROW_ITEM, 0, 1, 30000, 1000));
      script.push_back(req_row(ROW_ITEM, 1, 1, -30000, -1000));
      script.push_back(req_row(ROW_ITEM, 2, 1, 32767, 32767));
      script.push_back(req_row(ROW_ITEM, 2, 0, 32767, -32768));
      script.push_back(req_row(ROW_ITEM, 5, 0, -32768, 20000));
      script.push_back(req_row(ROW_ITEM, 0, 1, 100, -20000));

      foreach (script[i]) begin
         if (script[i].kind == ROW_WRITE) begin
            wait_drained();
            write_register(script[i].reg_index, script[i].reg_value);
         end else begin
            send_request(script[i].rq, 0, script[i].kind == ROW_TYPED, script[i].want);
         end
      end

      // Back-to-back traffic, opened by a long hold-off on the response side so
      // the pipeline fills and the block has to stall its request input.
      start_phase(3, 32768, 0);
      hold_off_asks <= hold_off_asks + 1;
      run_frames(250, 0);

      // Sparse requests; halfway through the sender stops until every owed
      // response has come back, then carries on.
      start_phase(100, int'($urandom_range(65535, 1)), 0);
      run_frames(120, 87);
      wait_drained();
      run_frames(130, 87);

      // Saturating hold level with a response side that stalls most cycles.
      start_phase(7, 65535, 87);
      run_frames(250, 0);

      // Refresh every other frame with a zero level, both sides idling.
      start_phase(1, 0, 38);
      run_frames(250, 38);

      // The largest period, with the counter compared one bit wider than it is
      // stored; every request here starts a frame.
      start_phase(65535, 32768, 0);
      for (n = 0; n < WIDE_ITEMS; n++) begin
         rq.voice = 3'(n);
         rq.frame_start = 1'b1;
         rq.white = noise_word();
         rq.hold = noise_word();
         send_request(rq, 0);
      end

      // Top of the usual period range, random level.
      start_phase(50100, int'($urandom_range(65535)), 38);
      run_frames(60, 38);

      // Let the pipeline run out; nothing more may come back after this.
      wait_drained();
      repeat (8) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses under stalls on both sides;",
               requests_sent, results_checked);
      $display("%0d refresh frames, hold period from 0 to 65535, level from 0 to 65535.",
               refresh_frames);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches found.", mismatch_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // The slowest correct run needs well under a tenth of this.
   initial begin : watchdog
      #10ms;
      $display("Timed out with %0d responses still owed.", pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
